>>> hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Request/response payload structs, request and status codes, cell control struct.
// No dependencies.
`default_nettype none

package deq_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_WIDTH = 5;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;
  localparam logic [2:0] REQ_QUERY      = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
    logic [COUNT_WIDTH-1:0]       entry_count;
    logic                         is_empty;
    logic [1:0]                   status;
  } rsp_t;

  // Per-cycle command broadcast to every cell; only legal operations are set.
  typedef struct packed {
    logic add_front;
    logic add_back;
    logic drop_front;
    logic drop_back;
    logic clear;
  } cell_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/double_ended_queue.sv
// Double-ended queue of signed words built as a chain of shifting cells.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one request per cycle; the response register blocks a new
// request only while a response is held by the consumer.
// Reset (synchronous): all cells invalid, count zero, no response pending;
// stored words are not cleared.
`default_nettype none

module double_ended_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire deq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output deq_pkg::rsp_t      rsp
);

  localparam int DW = deq_pkg::DATA_WIDTH;
  localparam int CW = deq_pkg::COUNT_WIDTH;
  localparam int N  = deq_pkg::DEPTH;

  logic [DW-1:0] cell_data [N];
  logic [N-1:0]  cell_valid;
  logic [DW-1:0] tail_data [N];

  logic [CW-1:0] count, count_next;
  logic [1:0]    status, status_next;
  deq_pkg::cell_op_t op;
  logic          accept, full, empty;
  logic [DW-1:0] back_word;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(N));
  assign empty     = (count == '0);

  always_comb begin
    op          = '0;
    count_next  = count;
    status_next = deq_pkg::ST_DONE;
    unique case (req.req_type)
      deq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          op.add_front = accept;
          count_next   = count + CW'(1);
        end
      end
      deq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          op.add_back = accept;
          count_next  = count + CW'(1);
        end
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          op.drop_front = accept;
          count_next    = count - CW'(1);
        end
      end
      deq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          op.drop_back = accept;
          count_next   = count - CW'(1);
        end
      end
      deq_pkg::REQ_CLEAR: begin
        op.clear   = accept;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [DW-1:0] prev_d, succ_d;
    logic          prev_v, succ_v;

    if (i == 0) begin : g_head
      assign prev_d = req.push_value;
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_v = cell_valid[i-1];
    end

    if (i == N-1) begin : g_last
      assign succ_d = '0;
      assign succ_v = 1'b0;
    end else begin : g_inner
      assign succ_d = cell_data[i+1];
      assign succ_v = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .push_value (req.push_value),
      .prev_data  (prev_d),
      .prev_valid (prev_v),
      .succ_data  (succ_d),
      .succ_valid (succ_v),
      .data       (cell_data[i]),
      .valid      (cell_valid[i])
    );

    assign tail_data[i] = (cell_valid[i] && !succ_v) ? cell_data[i] : '0;
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < N; i++) begin
      back_word = back_word | tail_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      status    <= deq_pkg::ST_DONE;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.front_value = empty ? '1 : cell_data[0];
    rsp.back_value  = empty ? '1 : back_word;
    rsp.entry_count = count;
    rsp.is_empty    = empty;
    rsp.status      = status;
  end

  // Occupied cells always form a contiguous run from the head.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + N'(1))) == '0)
    else $error("cell valid bits not contiguous");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("count disagrees with occupied cells");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (req.req_type == deq_pkg::REQ_PUSH_FRONT ||
                        req.req_type == deq_pkg::REQ_PUSH_BACK))
    |=> (rsp.status == deq_pkg::ST_FULL) && $stable(cell_valid))
    else $error("push on full queue not dropped");

  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("no response after request transfer");

endmodule

`default_nettype wire

>>> hw/rtl/deq_cell.sv
// One storage cell of the deque chain: a word and its valid bit.
// Shifts with its neighbors on front push/pop, fills or drains at the tail.
// Depends on deq_pkg.
`default_nettype none

module deq_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire deq_pkg::cell_op_t                  op,
  input  wire logic [deq_pkg::DATA_WIDTH-1:0]     push_value,
  input  wire logic [deq_pkg::DATA_WIDTH-1:0]     prev_data,
  input  wire logic                               prev_valid,
  input  wire logic [deq_pkg::DATA_WIDTH-1:0]     succ_data,
  input  wire logic                               succ_valid,
  output logic      [deq_pkg::DATA_WIDTH-1:0]     data,
  output logic                                    valid
);

  logic [deq_pkg::DATA_WIDTH-1:0] data_next;
  logic                           valid_next;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    priority if (op.clear) begin
      valid_next = 1'b0;
    end else if (op.add_front) begin
      data_next  = prev_data;
      valid_next = prev_valid;
    end else if (op.add_back) begin
      if (!valid && prev_valid) begin
        data_next  = push_value;
        valid_next = 1'b1;
      end
    end else if (op.drop_front) begin
      data_next  = succ_data;
      valid_next = succ_valid;
    end else if (op.drop_back) begin
      if (valid && !succ_valid) begin
        valid_next = 1'b0;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire
